// ----- hdl/kpeq_pkg.sv -----
// shared types, constants and key placement table for the keypad press edge queue
package kpeq_pkg;

  localparam int unsigned NumKeys  = 16;
  localparam int unsigned KeyW     = 4;
  localparam int unsigned ScanW    = 48;
  localparam int unsigned PosW     = 6;
  localparam int unsigned LevelW   = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_FINISH
  } state_e;

  typedef enum logic {
    FUNC_SCAN = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  // scan byte in the high nibble, bit within the byte in the low nibble
  localparam logic [7:0] KeyPlace [NumKeys] = '{
    8'h07, 8'h04, 8'h02, 8'h22,
    8'h05, 8'h06, 8'h00, 8'h01,
    8'h03, 8'h10, 8'h30, 8'h21,
    8'h13, 8'h12, 8'h11, 8'h31
  };

  // bit position of a key inside the 48-bit scan word
  function automatic logic [PosW-1:0] key_pos(input logic [KeyW-1:0] key);
    logic [7:0] code;
    code    = KeyPlace[key];
    key_pos = {code[6:4], 3'b000} + {2'b00, code[3:0]};
  endfunction

endpackage

// ----- hdl/keypad_press_edge_queue.sv -----
// keypad press edge queue: scan edge detection and circular press queue
//
// each input transaction is either a keypad scan (func_i = 0) or a pop request
// (func_i = 1) and gives exactly one output transaction. a scan is compared
// against the previous scan; keys newly pressed are walked one key per cycle
// in ascending key order and pushed into a circular queue of QUEUE_DEPTH
// entries, dropping the oldest entry when the queue is full. a scan passes
// through an accept step, 16 key steps and a result step; a pop passes through
// an accept step, a read step and a result step, the read being served by the
// registered read of the queue memory. the result waits in an output register
// and a new transaction is taken once the previous result has been loaded there.
// queue_level_o reports the queue fill modulo 32. queue entries carry no reset.
module keypad_press_edge_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [47:0] scan_bits_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  key_code_o,
  output logic        key_valid_o,
  output logic        press_event_o,
  output logic [4:0]  queue_level_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // wrap a queue pointer at the queue depth
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  kpeq_pkg::state_e state_q, state_d;

  // scan history and new press mask
  logic [kpeq_pkg::ScanW-1:0] prev_scan_q, prev_scan_d;
  logic [kpeq_pkg::ScanW-1:0] new_mask_q, new_mask_d;
  logic [kpeq_pkg::KeyW-1:0]  key_q, key_d;

  // queue bookkeeping
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            queue_full;
  logic            key_hit;

  // queue storage, registered read at the head
  logic [kpeq_pkg::KeyW-1:0] queue_mem [QUEUE_DEPTH];
  logic [kpeq_pkg::KeyW-1:0] rd_data_q;
  logic                      mem_we;

  // result being built
  logic [kpeq_pkg::KeyW-1:0] res_code_q, res_code_d;
  logic                      res_valid_q, res_valid_d;
  logic                      event_q, event_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [kpeq_pkg::KeyW-1:0] out_code_q, out_code_d;
  logic                      out_kvalid_q, out_kvalid_d;
  logic                      out_event_q, out_event_d;
  logic [4:0]                out_level_q, out_level_d;

  logic in_take;
  logic out_free;

  assign in_stall_o = (state_q != kpeq_pkg::ST_IDLE);
  assign in_take    = in_valid_i && (state_q == kpeq_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign queue_full = (count_q == CntW'(QUEUE_DEPTH));
  // key under test is pressed now and was released in the previous scan
  assign key_hit    = new_mask_q[kpeq_pkg::key_pos(key_q)];
  assign mem_we     = (state_q == kpeq_pkg::ST_SCAN) && key_hit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kpeq_pkg::ST_IDLE: begin
        if (in_take) begin
          if (func_i == kpeq_pkg::FUNC_SCAN) begin
            state_d = kpeq_pkg::ST_SCAN;
          end else if (count_q != '0) begin
            state_d = kpeq_pkg::ST_POP;
          end else begin
            // pop on an empty queue reports nothing
            state_d = kpeq_pkg::ST_FINISH;
          end
        end
      end
      kpeq_pkg::ST_SCAN: begin
        if (key_q == kpeq_pkg::KeyW'(kpeq_pkg::NumKeys - 1)) begin
          state_d = kpeq_pkg::ST_FINISH;
        end
      end
      kpeq_pkg::ST_POP: begin
        state_d = kpeq_pkg::ST_FINISH;
      end
      kpeq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = kpeq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kpeq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and output updates
  always_comb begin
    prev_scan_d  = prev_scan_q;
    new_mask_d   = new_mask_q;
    key_d        = key_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    res_code_d   = res_code_q;
    res_valid_d  = res_valid_q;
    event_d      = event_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_code_d   = out_code_q;
    out_kvalid_d = out_kvalid_q;
    out_event_d  = out_event_q;
    out_level_d  = out_level_q;
    case (state_q)
      kpeq_pkg::ST_IDLE: begin
        if (in_take) begin
          res_code_d  = '0;
          res_valid_d = 1'b0;
          event_d     = 1'b0;
          key_d       = '0;
          if (func_i == kpeq_pkg::FUNC_SCAN) begin
            new_mask_d  = scan_bits_i & ~prev_scan_q;
            prev_scan_d = scan_bits_i;
          end
        end
      end
      kpeq_pkg::ST_SCAN: begin
        key_d = key_q + 1'b1;
        if (key_hit) begin
          event_d = 1'b1;
          tail_d  = ptr_inc(tail_q);
          if (queue_full) begin
            // full queue loses its oldest press
            head_d = ptr_inc(head_q);
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      kpeq_pkg::ST_POP: begin
        res_code_d  = rd_data_q;
        res_valid_d = 1'b1;
        head_d      = ptr_inc(head_q);
        count_d     = count_q - 1'b1;
      end
      kpeq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_code_d   = res_code_q;
          out_kvalid_d = res_valid_q;
          out_event_d  = event_q;
          out_level_d  = 5'(count_q);
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpeq_pkg::ST_IDLE;
      prev_scan_q <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_scan_q <= prev_scan_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    new_mask_q   <= new_mask_d;
    key_q        <= key_d;
    res_code_q   <= res_code_d;
    res_valid_q  <= res_valid_d;
    event_q      <= event_d;
    out_code_q   <= out_code_d;
    out_kvalid_q <= out_kvalid_d;
    out_event_q  <= out_event_d;
    out_level_q  <= out_level_d;
  end

  // queue memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[tail_q] <= key_q;
    end
    rd_data_q <= queue_mem[head_q];
  end

  assign out_valid_o   = out_valid_q;
  assign key_code_o    = out_code_q;
  assign key_valid_o   = out_kvalid_q;
  assign press_event_o = out_event_q;
  assign queue_level_o = out_level_q;

endmodule

// ----- test/keypad_press_edge_queue_tb.sv -----
// self-checking testbench for the keypad press edge queue
module keypad_press_edge_queue_tb;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned ItemsPerPhase = 275;

  // byte of the scan word in the high nibble, bit within that byte in the low nibble
  localparam logic [7:0] KeyCode [16] = '{
    8'h07, 8'h04, 8'h02, 8'h22,
    8'h05, 8'h06, 8'h00, 8'h01,
    8'h03, 8'h10, 8'h30, 8'h21,
    8'h13, 8'h12, 8'h11, 8'h31
  };

  typedef struct packed {
    logic [3:0] key_code;
    logic       key_valid;
    logic       press_event;
    logic [4:0] queue_level;
  } key_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  kpeq_pkg::func_e  in_func = kpeq_pkg::FUNC_SCAN;
  logic [47:0]      in_scan = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       out_key_code;
  logic             out_key_valid;
  logic             out_press_event;
  logic [4:0]       out_queue_level;

  // predictor state: last scan seen and the queued key presses
  logic [47:0] held_scan = '0;
  logic [3:0]  press_fifo [$];
  key_result_t due_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  keypad_press_edge_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (in_func),
    .scan_bits_i  (in_scan),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .key_code_o   (out_key_code),
    .key_valid_o  (out_key_valid),
    .press_event_o(out_press_event),
    .queue_level_o(out_queue_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scan-word mask of one key
  function automatic logic [47:0] key_mask(int unsigned key);
    logic [7:0] code;
    int unsigned pos;
    code = KeyCode[key];
    pos  = code[6:4] * 8 + code[3:0];
    key_mask = '0;
    if (pos < 48) key_mask[pos] = 1'b1;
  endfunction

  // every scan bit that belongs to some key
  function automatic logic [47:0] all_keys_mask();
    all_keys_mask = '0;
    for (int k = 0; k < 16; k++) all_keys_mask |= key_mask(k);
  endfunction

  function automatic logic [47:0] random_scan();
    random_scan = 48'({$urandom(), $urandom()});
  endfunction

  // work out the result of one accepted transaction and advance the predictor
  task automatic predict_press_queue(kpeq_pkg::func_e f, logic [47:0] bits);
    key_result_t res;
    res = '0;
    if (f == kpeq_pkg::FUNC_SCAN) begin
      // new presses go in ascending key order, oldest dropped when full
      for (int k = 0; k < 16; k++) begin
        if ((bits & key_mask(k)) != 0 && (held_scan & key_mask(k)) == 0) begin
          if (press_fifo.size() >= QueueDepth) void'(press_fifo.pop_front());
          press_fifo.push_back(k[3:0]);
          res.press_event = 1'b1;
        end
      end
      held_scan = bits;
    end else if (press_fifo.size() > 0) begin
      // pop leaves the held scan alone
      res.key_code  = press_fifo.pop_front();
      res.key_valid = 1'b1;
    end
    res.queue_level = 5'(press_fifo.size() % 32);
    due_results.push_back(res);
  endtask

  // present one transaction, hold it until accepted, then predict it
  task automatic send_item(kpeq_pkg::func_e f, logic [47:0] bits);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_scan  <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_press_queue(f, bits);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // output side: compare each accepted result, then pick the next stall
  always @(posedge clk) begin
    key_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, %s %0d valid %0d event %0d level %0d",
                 $time, "actual code", out_key_code, out_key_valid, out_press_event,
                 out_queue_level);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("key_code", int'(want.key_code), int'(out_key_code));
        check_field("key_valid", int'(want.key_valid), int'(out_key_valid));
        check_field("press_event", int'(want.press_event), int'(out_press_event));
        check_field("queue_level", int'(want.queue_level), int'(out_queue_level));
      end
    end
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // pop on an empty queue, with a scan field that must be ignored
  task automatic test_pop_empty();
    send_item(kpeq_pkg::FUNC_POP, '1);
  endtask

  // every key at once fills the queue in key order; repeating it adds nothing
  task automatic test_all_keys();
    send_item(kpeq_pkg::FUNC_SCAN, '1);
    send_item(kpeq_pkg::FUNC_SCAN, '1);
  endtask

  // release everything, then press one key with the queue full
  task automatic test_push_on_full();
    send_item(kpeq_pkg::FUNC_SCAN, '0);
    send_item(kpeq_pkg::FUNC_SCAN, key_mask(15));
  endtask

  // a pop must not touch the held scan, so the same key is not new again
  task automatic test_pop_keeps_scan();
    send_item(kpeq_pkg::FUNC_POP, '1);
    send_item(kpeq_pkg::FUNC_SCAN, key_mask(15));
  endtask

  // bits outside the key table never count as a press
  task automatic test_unmapped_bits();
    send_item(kpeq_pkg::FUNC_SCAN, ~all_keys_mask());
  endtask

  // empty the queue and pop once more
  task automatic test_drain();
    while (press_fifo.size() > 0) send_item(kpeq_pkg::FUNC_POP, random_scan());
    send_item(kpeq_pkg::FUNC_POP, '0);
  endtask

  // mostly small changes to the held scan, some full random scans, mixed with pops
  task automatic test_random_traffic();
    int unsigned idle_pct [4]  = '{0, 70, 0, 16};
    int unsigned stall_pct [4] = '{0, 0, 70, 16};
    int unsigned pop_pct;
    logic [47:0] bits;
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pct[ph];
      sink_stall_pct  = stall_pct[ph];
      pop_pct = 40;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // shift the pop share now and then so the level sweeps empty to full
        if (n % 50 == 0) pop_pct = $urandom_range(15, 75);
        if ($urandom_range(99) < pop_pct) begin
          send_item(kpeq_pkg::FUNC_POP, random_scan());
        end else begin
          case ($urandom_range(9))
            0: bits = random_scan();
            1: bits = '0;
            default: begin
              bits = held_scan;
              repeat ($urandom_range(1, 3)) bits ^= key_mask($urandom_range(15));
              bits = (bits & all_keys_mask()) | (random_scan() & ~all_keys_mask());
            end
          endcase
          send_item(kpeq_pkg::FUNC_SCAN, bits);
        end
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_pop_empty();
    test_all_keys();
    test_push_on_full();
    test_pop_keeps_scan();
    test_unmapped_bits();
    test_drain();
    test_random_traffic();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog on a hung handshake
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/kpeq_pkg.sv
hdl/keypad_press_edge_queue.sv
test/keypad_press_edge_queue_tb.sv
